// ----- rtl/lrh_pkg.sv -----
// Shared types, codes and constants of the link role handshake block.
`timescale 1ns / 1ps
package lrh_pkg;

  localparam int unsigned ELAPSED_WIDTH_DEFAULT = 16;
  localparam int unsigned TIMEOUT_W             = 10;
  localparam int unsigned LIMIT_W               = 4;
  localparam int unsigned ATTEMPT_W             = 5;
  localparam int unsigned CFG_INDEX_W           = 4;
  localparam int unsigned CFG_DATA_W            = 10;

  localparam logic [TIMEOUT_W-1:0] REQUEST_TIMEOUT_RESET = 10'd500;
  localparam logic [TIMEOUT_W-1:0] OFFER_TIMEOUT_RESET   = 10'd500;
  localparam logic [LIMIT_W-1:0]   REQUEST_LIMIT_RESET   = 4'd10;
  localparam logic [LIMIT_W-1:0]   OFFER_LIMIT_RESET     = 4'd10;

  localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX = '1;

  localparam logic [CFG_INDEX_W-1:0] CFG_REQUEST_TIMEOUT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFER_TIMEOUT   = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REQUEST_LIMIT   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFER_LIMIT     = 4'd3;

  localparam logic [1:0] ROLE_NONE = 2'd0;
  localparam logic [1:0] ROLE_S1   = 2'd1;
  localparam logic [1:0] ROLE_S2   = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_OFFER   = 2'd2,
    CMD_ACK     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MSG_NONE    = 2'd0,
    MSG_REQUEST = 2'd1,
    MSG_OFFER   = 2'd2,
    MSG_ACK     = 2'd3
  } msg_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] request_timeout_ms;
    logic [TIMEOUT_W-1:0] offer_timeout_ms;
    logic [LIMIT_W-1:0]   request_retry_limit;
    logic [LIMIT_W-1:0]   offer_retry_limit;
  } cfg_t;

  function automatic logic [ATTEMPT_W-1:0] bump(input logic [ATTEMPT_W-1:0] c);
    logic [ATTEMPT_W-1:0] r;
    r = (c == ATTEMPT_MAX) ? c : c + 1'b1;
    return r;
  endfunction

endpackage

// ----- rtl/lrh_ifs.sv -----
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps
interface lrh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] peer_first_role;
  logic [1:0] peer_second_role;
  modport source (output valid, cmd, peer_first_role, peer_second_role, input ready);
  modport sink (input valid, cmd, peer_first_role, peer_second_role, output ready);
endinterface

interface lrh_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] send_kind;
  logic [1:0] send_first_role;
  logic [1:0] send_second_role;
  logic       start_server;
  logic       reannounce_bindings;
  logic [1:0] own_role;
  logic [1:0] partner_role;
  logic [1:0] phase_now;
  modport source (output valid, send_kind, send_first_role, send_second_role, start_server,
                  reannounce_bindings, own_role, partner_role, phase_now, input ready);
  modport sink (input valid, send_kind, send_first_role, send_second_role, start_server,
                reannounce_bindings, own_role, partner_role, phase_now, output ready);
endinterface

interface lrh_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lrh_pkg::CFG_INDEX_W-1:0] index;
  logic [lrh_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/link_role_handshake_unit.sv -----
// Top level of the link role handshake block.
//
//   channel     direction  carries
//   item_in     in         cmd, peer_first_role, peer_second_role
//   result_out  out        send_kind, send roles, pulses, own/partner role, phase_now
//   cfg         in         index, data: timeouts and retry limits
//
// One item per cycle is accepted unless the result side stalls; each gives exactly one result,
// registered in the input register and then in the result register around the state update.
// The negotiation state is updated as an item moves into the result register.
// Reset clears the state and loads the default timeouts and limits.
// A stalled result holds one item in the input register, after which item_in stalls.
`timescale 1ns / 1ps
module link_role_handshake_unit #(
  parameter int unsigned ELAPSED_WIDTH = lrh_pkg::ELAPSED_WIDTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  lrh_in_if.sink    item_in,
  lrh_out_if.source result_out,
  lrh_cfg_if.sink   cfg
);
  import lrh_pkg::*;

  cfg_t regs;

  lrh_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lrh_engine #(
    .ELAPSED_WIDTH (ELAPSED_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .item_in    (item_in),
    .result_out (result_out)
  );

endmodule

// ----- rtl/lrh_cfg.sv -----
// Configuration register file: timeouts and retry limits.
`timescale 1ns / 1ps
module lrh_cfg (
  input  logic          clk,
  input  logic          rst,
  lrh_cfg_if.sink       cfg,
  output lrh_pkg::cfg_t regs
);
  import lrh_pkg::*;

  cfg_t regs_q;

  assign cfg.ready = 1'b1;
  assign regs      = regs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q.request_timeout_ms  <= REQUEST_TIMEOUT_RESET;
      regs_q.offer_timeout_ms    <= OFFER_TIMEOUT_RESET;
      regs_q.request_retry_limit <= REQUEST_LIMIT_RESET;
      regs_q.offer_retry_limit   <= OFFER_LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_REQUEST_TIMEOUT: regs_q.request_timeout_ms  <= cfg.data[TIMEOUT_W-1:0];
        CFG_OFFER_TIMEOUT:   regs_q.offer_timeout_ms    <= cfg.data[TIMEOUT_W-1:0];
        CFG_REQUEST_LIMIT:   regs_q.request_retry_limit <= cfg.data[LIMIT_W-1:0];
        CFG_OFFER_LIMIT:     regs_q.offer_retry_limit   <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/lrh_engine.sv -----
// Input register, negotiation state update and result register.
`timescale 1ns / 1ps
module lrh_engine #(
  parameter int unsigned ELAPSED_WIDTH = lrh_pkg::ELAPSED_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  lrh_pkg::cfg_t regs,
  lrh_in_if.sink       item_in,
  lrh_out_if.source    result_out
);
  import lrh_pkg::*;

  localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = '1;

  // Input register
  logic       s1_valid;
  logic [1:0] s1_cmd;
  logic [1:0] s1_r1;
  logic [1:0] s1_r2;

  // Negotiation state
  phase_t                 phase;
  logic [1:0]             self_role;
  logic [1:0]             peer_role;
  logic [ELAPSED_WIDTH-1:0] elapsed_ms;
  logic [ATTEMPT_W-1:0]   request_attempts;
  logic [ATTEMPT_W-1:0]   offer_attempts;

  phase_t                 phase_next;
  logic [1:0]             self_role_next;
  logic [1:0]             peer_role_next;
  logic [ELAPSED_WIDTH-1:0] elapsed_ms_next;
  logic [ATTEMPT_W-1:0]   request_attempts_next;
  logic [ATTEMPT_W-1:0]   offer_attempts_next;

  logic [ELAPSED_WIDTH-1:0] elapsed_inc;
  logic [ATTEMPT_W-1:0]   req_bumped;
  logic [ATTEMPT_W-1:0]   off_bumped;
  logic                   match;
  msg_t                   kind;
  logic                   start;
  logic                   reann;

  // Result register
  logic o_valid;
  logic adv;

  // The result register frees up when empty or when its item is taken this cycle.
  assign adv           = !o_valid || result_out.ready;
  assign item_in.ready = !s1_valid || adv;
  assign result_out.valid = o_valid;

  assign elapsed_inc = (elapsed_ms == ELAPSED_MAX) ? elapsed_ms : elapsed_ms + 1'b1;
  assign req_bumped  = bump(request_attempts);
  assign off_bumped  = bump(offer_attempts);
  assign match       = (s1_r2 == self_role) && (s1_r1 == peer_role);

  always_comb begin
    phase_next            = phase;
    self_role_next        = self_role;
    peer_role_next        = peer_role;
    elapsed_ms_next       = elapsed_ms;
    request_attempts_next = request_attempts;
    offer_attempts_next   = offer_attempts;
    kind                  = MSG_NONE;
    start                 = 1'b0;
    reann                 = 1'b0;
    case (s1_cmd)
      CMD_TICK: begin
        elapsed_ms_next = elapsed_inc;
        if (phase == PH_IDLE &&
            elapsed_inc > ELAPSED_WIDTH'(regs.request_timeout_ms)) begin
          request_attempts_next = req_bumped;
          if (req_bumped > ATTEMPT_W'(regs.request_retry_limit)) begin
            self_role_next = ROLE_S1;
            peer_role_next = ROLE_S2;
            phase_next     = PH_DONE;
            start          = 1'b1;
          end else begin
            kind            = MSG_REQUEST;
            elapsed_ms_next = '0;
          end
        end else if (phase == PH_WAIT &&
                     elapsed_inc > ELAPSED_WIDTH'(regs.offer_timeout_ms)) begin
          offer_attempts_next = off_bumped;
          if (off_bumped > ATTEMPT_W'(regs.offer_retry_limit)) begin
            phase_next = PH_DONE;
          end else begin
            kind            = MSG_OFFER;
            elapsed_ms_next = '0;
          end
        end
      end
      CMD_REQUEST: begin
        if (phase == PH_IDLE) begin
          self_role_next = ROLE_S1;
          peer_role_next = ROLE_S2;
          phase_next     = PH_WAIT;
        end
        kind                = MSG_OFFER;
        offer_attempts_next = '0;
      end
      CMD_OFFER: begin
        if (phase == PH_IDLE) begin
          self_role_next = s1_r2;
          peer_role_next = s1_r1;
          kind           = MSG_ACK;
          phase_next     = PH_DONE;
          start          = 1'b1;
        end else if (match) begin
          kind = MSG_ACK;
          if (phase == PH_WAIT) begin
            phase_next = PH_DONE;
            start      = 1'b1;
          end else begin
            reann = 1'b1;
          end
        end
      end
      CMD_ACK: begin
        if (phase != PH_IDLE && match) begin
          if (phase == PH_WAIT) begin
            phase_next = PH_DONE;
            start      = 1'b1;
          end else begin
            reann = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      o_valid          <= 1'b0;
      phase            <= PH_IDLE;
      self_role        <= ROLE_NONE;
      peer_role        <= ROLE_NONE;
      elapsed_ms       <= '0;
      request_attempts <= '0;
      offer_attempts   <= '0;
    end else begin
      if (item_in.valid && item_in.ready) begin
        s1_valid <= 1'b1;
        s1_cmd   <= item_in.cmd;
        s1_r1    <= item_in.peer_first_role;
        s1_r2    <= item_in.peer_second_role;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        o_valid <= s1_valid;
      end
      if (adv && s1_valid) begin
        phase            <= phase_next;
        self_role        <= self_role_next;
        peer_role        <= peer_role_next;
        elapsed_ms       <= elapsed_ms_next;
        request_attempts <= request_attempts_next;
        offer_attempts   <= offer_attempts_next;
        result_out.send_kind           <= kind;
        result_out.send_first_role     <=
          (kind == MSG_OFFER || kind == MSG_ACK) ? self_role_next : ROLE_NONE;
        result_out.send_second_role    <=
          (kind == MSG_OFFER || kind == MSG_ACK) ? peer_role_next : ROLE_NONE;
        result_out.start_server        <= start;
        result_out.reannounce_bindings <= reann;
        result_out.own_role            <= self_role_next;
        result_out.partner_role        <= peer_role_next;
        result_out.phase_now           <= phase_next;
      end
    end
  end

  a_start_means_done: assert property (@(posedge clk) disable iff (rst)
    o_valid && result_out.start_server |-> result_out.phase_now == PH_DONE)
    else $error("start_server pulsed outside the finished phase");

  a_pulses_exclusive: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> !(result_out.start_server && result_out.reannounce_bindings))
    else $error("start_server and reannounce_bindings in the same item");

  a_roles_only_with_offer_ack: assert property (@(posedge clk) disable iff (rst)
    o_valid && (result_out.send_kind == MSG_NONE || result_out.send_kind == MSG_REQUEST)
    |-> result_out.send_first_role == ROLE_NONE && result_out.send_second_role == ROLE_NONE)
    else $error("roles sent with a message that carries none");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(phase) == PH_DONE |-> phase == PH_DONE)
    else $error("negotiation left the finished phase");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !item_in.ready |-> s1_valid && o_valid)
    else $error("input stalled while a stage was free");

endmodule

// ----- tb/tb_link_role_handshake_unit.sv -----
// Self-checking testbench that walks the link role handshake unit through its negotiation phases.
`timescale 1ns / 1ps
module tb_link_role_handshake_unit;
  import lrh_pkg::*;

  localparam int          ELAPSED_W   = ELAPSED_WIDTH_DEFAULT;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [1:0]  ROLE_SPARE  = 2'd3;

  typedef struct packed {
    msg_t       kind;
    logic [1:0] first_role;
    logic [1:0] second_role;
    logic       start;
    logic       reann;
    logic [1:0] own;
    logic [1:0] partner;
    phase_t     ph;
  } reply_t;

  logic clk = 1'b0;
  logic rst;
  logic accept_replies = 1'b0;

  lrh_in_if  item_if ();
  lrh_out_if reply_if ();
  lrh_cfg_if cfg_if ();

  assign reply_if.ready = accept_replies;

  link_role_handshake_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_if),
    .result_out (reply_if),
    .cfg        (cfg_if)
  );

  // Negotiation state as the block should hold it.
  cfg_t                 link_cfg;
  phase_t               neg_phase;
  logic [1:0]           own_role_q;
  logic [1:0]           partner_role_q;
  logic [ELAPSED_W-1:0] elapsed_ms;
  logic [ATTEMPT_W-1:0] request_tries;
  logic [ATTEMPT_W-1:0] offer_tries;

  reply_t replies_due[$];
  reply_t last_reply;
  reply_t want;

  int mismatches  = 0;
  int burst_left  = 0;
  int cycle_count = 0;
  int stall_mode  = 0;
  int stall_left  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // The receiver switches between free flow, coin-toss acceptance and long stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        accept_replies <= 1'b1;
      end
      1: begin
        accept_replies <= 1'($urandom_range(0, 1));
      end
      default: begin
        accept_replies <= ($urandom_range(0, 5) == 0);
      end
    endcase
  end

  task automatic flag_mismatch(input string what, input int got, input int exp_v);
    if (mismatches < 40) begin
      $display("mismatch at %0t: %s is %0d, should be %0d", $time, what, got, exp_v);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && reply_if.valid && reply_if.ready) begin
      if (replies_due.size() == 0) begin
        flag_mismatch("reply with no item outstanding", reply_if.send_kind, 0);
      end else begin
        want = replies_due.pop_front();
        if (reply_if.send_kind !== want.kind)
          flag_mismatch("send_kind", reply_if.send_kind, want.kind);
        if (reply_if.send_first_role !== want.first_role)
          flag_mismatch("send_first_role", reply_if.send_first_role, want.first_role);
        if (reply_if.send_second_role !== want.second_role)
          flag_mismatch("send_second_role", reply_if.send_second_role, want.second_role);
        if (reply_if.start_server !== want.start)
          flag_mismatch("start_server", reply_if.start_server, want.start);
        if (reply_if.reannounce_bindings !== want.reann)
          flag_mismatch("reannounce_bindings", reply_if.reannounce_bindings, want.reann);
        if (reply_if.own_role !== want.own)
          flag_mismatch("own_role", reply_if.own_role, want.own);
        if (reply_if.partner_role !== want.partner)
          flag_mismatch("partner_role", reply_if.partner_role, want.partner);
        if (reply_if.phase_now !== want.ph)
          flag_mismatch("phase_now", reply_if.phase_now, want.ph);
      end
    end
  end

  // Advances the negotiation by one item and queues the reply it must produce.
  function automatic void negotiate_step(input cmd_t c, input logic [1:0] r1,
                                         input logic [1:0] r2);
    reply_t r;
    logic   hit;
    r.kind  = MSG_NONE;
    r.start = 1'b0;
    r.reann = 1'b0;
    hit = (r2 == own_role_q) && (r1 == partner_role_q);
    case (c)
      CMD_TICK: begin
        if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
        if (neg_phase == PH_IDLE && elapsed_ms > link_cfg.request_timeout_ms) begin
          if (request_tries != ATTEMPT_MAX) request_tries = request_tries + 1'b1;
          if (request_tries > link_cfg.request_retry_limit) begin
            own_role_q     = ROLE_S1;
            partner_role_q = ROLE_S2;
            neg_phase      = PH_DONE;
            r.start        = 1'b1;
          end else begin
            r.kind     = MSG_REQUEST;
            elapsed_ms = '0;
          end
        end else if (neg_phase == PH_WAIT && elapsed_ms > link_cfg.offer_timeout_ms) begin
          if (offer_tries != ATTEMPT_MAX) offer_tries = offer_tries + 1'b1;
          if (offer_tries > link_cfg.offer_retry_limit) begin
            // Giving up finishes quietly, with no server start.
            neg_phase = PH_DONE;
          end else begin
            r.kind     = MSG_OFFER;
            elapsed_ms = '0;
          end
        end
      end
      CMD_REQUEST: begin
        if (neg_phase == PH_IDLE) begin
          own_role_q     = ROLE_S1;
          partner_role_q = ROLE_S2;
          neg_phase      = PH_WAIT;
        end
        r.kind      = MSG_OFFER;
        offer_tries = '0;
      end
      CMD_OFFER: begin
        if (neg_phase == PH_IDLE) begin
          own_role_q     = r2;
          partner_role_q = r1;
          r.kind         = MSG_ACK;
          neg_phase      = PH_DONE;
          r.start        = 1'b1;
        end else if (hit) begin
          r.kind = MSG_ACK;
          if (neg_phase == PH_WAIT) begin
            neg_phase = PH_DONE;
            r.start   = 1'b1;
          end else begin
            r.reann = 1'b1;
          end
        end
      end
      default: begin
        if (neg_phase != PH_IDLE && hit) begin
          if (neg_phase == PH_WAIT) begin
            neg_phase = PH_DONE;
            r.start   = 1'b1;
          end else begin
            r.reann = 1'b1;
          end
        end
      end
    endcase
    if (r.kind == MSG_OFFER || r.kind == MSG_ACK) begin
      r.first_role  = own_role_q;
      r.second_role = partner_role_q;
    end else begin
      r.first_role  = ROLE_NONE;
      r.second_role = ROLE_NONE;
    end
    r.own     = own_role_q;
    r.partner = partner_role_q;
    r.ph      = neg_phase;
    replies_due.push_back(r);
    last_reply = r;
  endfunction

  function automatic logic [1:0] rand_role();
    return 2'($urandom_range(0, 3));
  endfunction

  // The sender runs in bursts; a burst of zero length means a gap after every item.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end
  endtask

  task automatic send_item(input cmd_t c, input logic [1:0] r1, input logic [1:0] r2);
    item_if.valid            <= 1'b1;
    item_if.cmd              <= c;
    item_if.peer_first_role  <= r1;
    item_if.peer_second_role <= r2;
    @(posedge clk);
    while (!(item_if.valid && item_if.ready)) @(posedge clk);
    negotiate_step(c, r1, r2);
    pace();
  endtask

  // Holds the sender off until every reply has come back and the pipeline is empty.
  task automatic settle();
    item_if.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!(cfg_if.valid && cfg_if.ready)) @(posedge clk);
    case (idx)
      CFG_REQUEST_TIMEOUT: link_cfg.request_timeout_ms  = value;
      CFG_OFFER_TIMEOUT:   link_cfg.offer_timeout_ms    = value;
      CFG_REQUEST_LIMIT:   link_cfg.request_retry_limit = value[LIMIT_W-1:0];
      CFG_OFFER_LIMIT:     link_cfg.offer_retry_limit   = value[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Limits sometimes carry junk above their four bits, and an unused index is written too.
  task automatic write_settings(input logic [TIMEOUT_W-1:0] req_to,
                                input logic [TIMEOUT_W-1:0] off_to,
                                input logic [LIMIT_W-1:0] req_lim,
                                input logic [LIMIT_W-1:0] off_lim);
    logic [5:0] junk;
    settle();
    junk = $urandom_range(0, 1) ? 6'($urandom_range(0, 63)) : 6'd0;
    write_register(CFG_REQUEST_TIMEOUT, req_to);
    write_register(CFG_OFFER_TIMEOUT, off_to);
    write_register(CFG_REQUEST_LIMIT, {junk, req_lim});
    write_register(CFG_OFFER_LIMIT, {junk, off_lim});
    write_register(CFG_OFFER_LIMIT + 4'($urandom_range(1, 12)), 10'($urandom_range(0, 1023)));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic tick_until(input msg_t k, input bit to_done);
    int n;
    n = 0;
    do begin
      send_item(CMD_TICK, rand_role(), rand_role());
      n++;
    end while (n < 4000 && (to_done ? neg_phase != PH_DONE : last_reply.kind != k));
  endtask

  task automatic test_idle_ignores();
    send_item(CMD_ACK, ROLE_NONE, ROLE_NONE);
    send_item(CMD_ACK, ROLE_SPARE, ROLE_SPARE);
    send_item(CMD_ACK, ROLE_S1, ROLE_S2);
    send_item(CMD_ACK, ROLE_S2, ROLE_S1);
    send_item(CMD_TICK, ROLE_SPARE, ROLE_SPARE);
    send_item(CMD_TICK, ROLE_NONE, ROLE_NONE);
  endtask

  // With the reset timeout a request goes out on the tick that passes it.
  task automatic test_default_request_timeout();
    tick_until(MSG_REQUEST, 1'b0);
    send_item(CMD_TICK, ROLE_S2, ROLE_S1);
  endtask

  task automatic test_request_timeout_zero();
    write_settings(10'd0, 10'd0, 4'd15, 4'd15);
    repeat (3) send_item(CMD_TICK, rand_role(), rand_role());
  endtask

  task automatic test_request_timeout_max();
    write_settings(10'd1023, 10'd1023, 4'd15, 4'd1);
    tick_until(MSG_REQUEST, 1'b0);
  endtask

  // Idle traffic stops short of the retry limit so that the exit can still be chosen.
  task automatic test_idle_random();
    int n;
    write_settings(10'($urandom_range(20, 60)), 10'($urandom_range(0, 1023)), 4'd15,
                   4'($urandom_range(1, 15)));
    n = 0;
    while (n < 100 && request_tries < 15) begin
      if ($urandom_range(0, 9) < 7) send_item(CMD_TICK, rand_role(), rand_role());
      else send_item(CMD_ACK, rand_role(), rand_role());
      n++;
    end
  endtask

  task automatic test_claim_alone();
    write_settings(10'($urandom_range(0, 3)), link_cfg.offer_timeout_ms,
                   $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(0, 15)),
                   link_cfg.offer_retry_limit);
    tick_until(MSG_NONE, 1'b1);
  endtask

  task automatic test_offer_while_idle();
    send_item(CMD_OFFER, rand_role(), rand_role());
  endtask

  task automatic test_request_while_idle();
    send_item(CMD_REQUEST, ROLE_SPARE, ROLE_SPARE);
    send_item(CMD_REQUEST, ROLE_NONE, ROLE_S1);
  endtask

  task automatic test_wait_ignores();
    send_item(CMD_OFFER, ROLE_S1, ROLE_S2);
    send_item(CMD_ACK, ROLE_S2, ROLE_S2);
    send_item(CMD_ACK, ROLE_NONE, ROLE_NONE);
    send_item(CMD_OFFER, ROLE_SPARE, ROLE_SPARE);
    send_item(CMD_ACK, ROLE_S1, ROLE_S1);
  endtask

  task automatic test_offer_timeout_zero();
    write_settings(link_cfg.request_timeout_ms, 10'd0, link_cfg.request_retry_limit, 4'd15);
    repeat (3) send_item(CMD_TICK, rand_role(), rand_role());
    send_item(CMD_REQUEST, rand_role(), rand_role());
  endtask

  task automatic test_offer_timeout_max();
    write_settings(link_cfg.request_timeout_ms, 10'd1023, link_cfg.request_retry_limit, 4'd15);
    tick_until(MSG_OFFER, 1'b0);
  endtask

  // Waiting traffic never matches, and a request resets the offer count before the limit.
  task automatic test_wait_random();
    logic [1:0] a;
    logic [1:0] b;
    write_settings(link_cfg.request_timeout_ms, 10'($urandom_range(10, 40)),
                   link_cfg.request_retry_limit, 4'd15);
    repeat (100) begin
      if (offer_tries >= 14) begin
        send_item(CMD_REQUEST, rand_role(), rand_role());
      end else begin
        case ($urandom_range(0, 19))
          0, 1: begin
            send_item(CMD_REQUEST, rand_role(), rand_role());
          end
          2, 3, 4, 5, 6, 7, 8: begin
            do begin
              a = rand_role();
              b = rand_role();
            end while (b == own_role_q && a == partner_role_q);
            send_item($urandom_range(0, 1) ? CMD_OFFER : CMD_ACK, a, b);
          end
          default: begin
            send_item(CMD_TICK, rand_role(), rand_role());
          end
        endcase
      end
    end
  endtask

  task automatic test_offer_give_up();
    write_settings(link_cfg.request_timeout_ms, 10'($urandom_range(0, 3)),
                   link_cfg.request_retry_limit, 4'($urandom_range(0, 2)));
    tick_until(MSG_NONE, 1'b1);
  endtask

  task automatic test_wait_match(input cmd_t c);
    send_item(c, partner_role_q, own_role_q);
  endtask

  task automatic test_done_directed();
    send_item(CMD_OFFER, partner_role_q, own_role_q);
    send_item(CMD_ACK, partner_role_q, own_role_q);
    send_item(CMD_OFFER, own_role_q, partner_role_q);
    send_item(CMD_ACK, ROLE_SPARE, ROLE_NONE);
    send_item(CMD_REQUEST, ROLE_NONE, ROLE_NONE);
    send_item(CMD_TICK, ROLE_SPARE, ROLE_SPARE);
  endtask

  // Once finished, the largest share of traffic is well-formed: matching offers and acknowledges.
  task automatic test_done_random(input int count);
    int pause_at;
    pause_at = $urandom_range(100, count - 100);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) settle();
      case ($urandom_range(0, 9))
        0, 1: send_item(CMD_OFFER, partner_role_q, own_role_q);
        2, 3: send_item(CMD_ACK, partner_role_q, own_role_q);
        4: send_item(CMD_OFFER, rand_role(), rand_role());
        5: send_item(CMD_ACK, rand_role(), rand_role());
        6: send_item(CMD_REQUEST, rand_role(), rand_role());
        default: send_item(CMD_TICK, rand_role(), rand_role());
      endcase
    end
  endtask

  initial begin
    int idle_exit;
    int wait_exit;
    bit went_through_wait;
    rst                      <= 1'b1;
    item_if.valid            <= 1'b0;
    item_if.cmd              <= CMD_TICK;
    item_if.peer_first_role  <= ROLE_NONE;
    item_if.peer_second_role <= ROLE_NONE;
    cfg_if.valid             <= 1'b0;
    cfg_if.index             <= CFG_REQUEST_TIMEOUT;
    cfg_if.data              <= '0;
    link_cfg.request_timeout_ms  = REQUEST_TIMEOUT_RESET;
    link_cfg.offer_timeout_ms    = OFFER_TIMEOUT_RESET;
    link_cfg.request_retry_limit = REQUEST_LIMIT_RESET;
    link_cfg.offer_retry_limit   = OFFER_LIMIT_RESET;
    neg_phase       = PH_IDLE;
    own_role_q      = ROLE_NONE;
    partner_role_q  = ROLE_NONE;
    elapsed_ms      = '0;
    request_tries   = '0;
    offer_tries     = '0;
    last_reply.kind = MSG_NONE;
    went_through_wait = 1'b0;
    // Idle can be left only once per run, so the way out is drawn at random.
    // The longest timeout is run on the request side or the offer side, never both.
    idle_exit = $urandom_range(0, 2);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_idle_ignores();
    test_default_request_timeout();
    test_request_timeout_zero();
    if (idle_exit != 2) test_request_timeout_max();
    test_idle_random();

    if (idle_exit == 0) begin
      test_claim_alone();
    end else if (idle_exit == 1) begin
      test_offer_while_idle();
    end else begin
      went_through_wait = 1'b1;
      test_request_while_idle();
      test_wait_ignores();
      test_offer_timeout_zero();
      test_offer_timeout_max();
      test_wait_random();
      wait_exit = $urandom_range(0, 2);
      if (wait_exit == 0) test_offer_give_up();
      else if (wait_exit == 1) test_wait_match(CMD_ACK);
      else test_wait_match(CMD_OFFER);
    end

    test_done_directed();
    test_done_random(went_through_wait ? 200 : 250);

    item_if.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lrh_pkg.sv
rtl/lrh_ifs.sv
rtl/lrh_cfg.sv
rtl/lrh_engine.sv
rtl/link_role_handshake_unit.sv
tb/tb_link_role_handshake_unit.sv
